// ===== rtl/rsi_pkg.sv =====
// Shared widths, constants and types for the streaming RSI indicator.
// No dependencies; imported by the serial units and the top level.
package rsi_pkg;

	localparam int PRICE_BITS  = 32;
	localparam int AVG_FRAC    = 8;
	localparam int PERIOD_BITS = 8;
	localparam int AVG_BITS    = PRICE_BITS + AVG_FRAC;
	localparam int SUM_BITS    = AVG_BITS + 1;
	localparam int NUM_BITS    = AVG_BITS + AVG_FRAC + 1;
	localparam int DIV_BITS    = SUM_BITS;
	localparam int MUL_BITS    = AVG_BITS + PERIOD_BITS;
	localparam int MUL_CNT_BITS = $clog2(PERIOD_BITS);
	localparam int STEP_BITS   = $clog2(NUM_BITS + 1);
	localparam int SEEN_BITS   = PERIOD_BITS + 1;
	localparam int RSI_BITS    = 15;
	localparam int RATIO_BITS  = 16;

	localparam logic [SEEN_BITS-1:0]   SEEN_CAP     = SEEN_BITS'(256);
	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);
	localparam logic [RSI_BITS-1:0]    RSI_FULL     = RSI_BITS'(25600);
	localparam logic [RSI_BITS-1:0]    RSI_HALF     = RSI_BITS'(12800);
	// 2 * 25600 = 200 << 8
	localparam logic [PERIOD_BITS-1:0] RSI_MUL      = PERIOD_BITS'(200);

	typedef struct packed {
		logic                 go;
		logic [STEP_BITS-1:0] steps;
	} div_req_t;

endpackage

// ===== rtl/rsi_mul_serial.sv =====
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// Uses rsi_pkg widths; product holds after done until the next start.
module rsi_mul_serial import rsi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [AVG_BITS-1:0]    a,
	input  logic [PERIOD_BITS-1:0] b,
	output logic                   done,
	output logic [MUL_BITS-1:0]    product
);

	logic [AVG_BITS-1:0]     a_q;
	logic [PERIOD_BITS-1:0]  b_q;
	logic [MUL_BITS-1:0]     acc_q;
	logic [MUL_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [MUL_BITS-1:0]     acc_next;

	always_comb begin
		acc_next = {acc_q[MUL_BITS-2:0], 1'b0};
		if (b_q[PERIOD_BITS-1]) begin
			acc_next = acc_next + MUL_BITS'(a_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_q    <= b;
				acc_q  <= '0;
				cnt_q  <= MUL_CNT_BITS'(PERIOD_BITS - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_next;
				b_q   <= {b_q[PERIOD_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/rsi_div_serial.sv =====
// Restoring divider, one quotient bit per cycle; dividend bits enter MSB first.
// Uses rsi_pkg; the initial remainder must be below the divisor.
module rsi_div_serial import rsi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  div_req_t            req,
	input  logic [DIV_BITS-1:0] rem_init,
	input  logic [NUM_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0] divisor,
	output logic                done,
	output logic [AVG_BITS-1:0] quotient
);

	logic [DIV_BITS-1:0]  rem_q;
	logic [NUM_BITS-1:0]  dvd_q;
	logic [DIV_BITS-1:0]  dvs_q;
	logic [AVG_BITS-1:0]  quo_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_BITS:0]    shifted;
	logic [DIV_BITS+1:0]  trial;
	logic                 ge;
	logic [DIV_BITS-1:0]  rem_next;

	always_comb begin
		shifted  = {rem_q, dvd_q[NUM_BITS-1]};
		trial    = {1'b0, shifted} - {2'b00, dvs_q};
		ge       = !trial[DIV_BITS+1];
		rem_next = ge ? trial[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				rem_q  <= rem_init;
				dvd_q  <= dividend;
				dvs_q  <= divisor;
				quo_q  <= '0;
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[NUM_BITS-2:0], 1'b0};
				quo_q <= {quo_q[AVG_BITS-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/streaming_rsi_indicator.sv =====
// Streaming Wilder RSI: sequencer, series state, output register.
// Depends on rsi_pkg, rsi_mul_serial and rsi_div_serial.
//
// One price beat in, one RSI beat out (1/256 units, 12800 with ready_res low until
// rsi_period+1 prices are seen). Items are handled one at a time. The item that ends
// seeding and any smoothing item use the single shared bit-serial divider, which runs
// two 40- or 49-step divisions by the period and one 16-step ratio division, and up to
// three serial multiplies. A zero average loss skips the ratio stage. A finished result
// waits in the output register while the next price is accepted. The next result is
// held back for as long as that register is still full. The user is to write
// rsi_period over the cfg channel only while the block is idle; the block itself does
// not enforce it. 0 acts as 1.
module streaming_rsi_indicator import rsi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [PERIOD_BITS-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [31:0]            price,
	input  logic                   restart,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [RSI_BITS-1:0]    rsi_value,
	output logic                   ready_res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIFF,
		S_SEED,
		S_CDIV,
		S_SMUL,
		S_MWAIT,
		S_SDIV,
		S_DWAIT,
		S_RSI,
		S_RMUL,
		S_RMWAIT,
		S_RDIV,
		S_RDWAIT,
		S_OUT
	} state_t;

	state_t                 state_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [PERIOD_BITS-1:0] p_q;
	logic [PRICE_BITS-1:0]  price_q;
	logic                   restart_q;
	logic [PRICE_BITS-1:0]  last_q;
	logic [AVG_BITS-1:0]    avg_g_q;
	logic [AVG_BITS-1:0]    avg_l_q;
	logic [SEEN_BITS-1:0]   seen_q;
	logic [PRICE_BITS-1:0]  gain_q;
	logic [PRICE_BITS-1:0]  loss_q;
	logic                   side_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [NUM_BITS-1:0]    num_q;
	logic [RSI_BITS-1:0]    res_val_q;
	logic                   res_rdy_q;
	logic                   out_valid_q;
	logic [RSI_BITS-1:0]    rsi_value_q;
	logic                   ready_res_q;

	logic [AVG_BITS-1:0]    cur_avg;
	logic [PRICE_BITS-1:0]  cur_chg;
	logic [SUM_BITS-1:0]    seed_sum;
	logic                   seed_mode;
	logic                   seed_end;
	logic [SEEN_BITS-1:0]   seen_next;
	logic                   ratio_ready;
	logic [RATIO_BITS:0]    rounded;

	logic                   mul_start;
	logic [AVG_BITS-1:0]    mul_a;
	logic [PERIOD_BITS-1:0] mul_b;
	logic                   mul_done;
	logic [MUL_BITS-1:0]    mul_prod;

	div_req_t               div_req;
	logic [DIV_BITS-1:0]    div_rem;
	logic [NUM_BITS-1:0]    div_dvd;
	logic [DIV_BITS-1:0]    div_dvs;
	logic                   div_done;
	logic [AVG_BITS-1:0]    div_quo;

	always_comb begin
		cur_avg     = side_q ? avg_l_q : avg_g_q;
		cur_chg     = side_q ? loss_q : gain_q;
		seed_sum    = {1'b0, cur_avg} + SUM_BITS'(cur_chg);
		seed_mode   = seen_q <= SEEN_BITS'(p_q);
		seed_end    = seen_q == SEEN_BITS'(p_q);
		seen_next   = (seen_q < SEEN_CAP) ? seen_q + 1'b1 : seen_q;
		ratio_ready = seen_next > SEEN_BITS'(p_q);
		rounded     = {1'b0, div_quo[RATIO_BITS-1:0]} + (RATIO_BITS + 1)'(1);
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = cur_avg;
		mul_b     = p_q - 1'b1;
		case (state_q)
			S_SMUL: begin
				mul_start = 1'b1;
			end
			S_RMUL: begin
				mul_start = 1'b1;
				mul_a     = avg_g_q;
				mul_b     = RSI_MUL;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		div_req.go    = 1'b0;
		div_req.steps = STEP_BITS'(AVG_BITS);
		div_rem       = {{(DIV_BITS-AVG_FRAC-1){1'b0}}, num_q[NUM_BITS-1:AVG_BITS]};
		div_dvd       = {num_q[AVG_BITS-1:0], {(NUM_BITS-AVG_BITS){1'b0}}};
		div_dvs       = DIV_BITS'(p_q);
		case (state_q)
			S_SDIV: begin
				div_req.go = 1'b1;
			end
			S_CDIV: begin
				div_req.go    = 1'b1;
				div_req.steps = STEP_BITS'(NUM_BITS);
				div_rem       = '0;
				div_dvd       = {sum_q, {AVG_FRAC{1'b0}}};
			end
			S_RDIV: begin
				div_req.go    = 1'b1;
				div_req.steps = STEP_BITS'(RATIO_BITS);
				div_rem       = {1'b0, mul_prod[MUL_BITS-1:AVG_FRAC]};
				div_dvd       = {mul_prod[AVG_FRAC-1:0], {(NUM_BITS-AVG_FRAC){1'b0}}};
				div_dvs       = sum_q;
			end
			default: begin
				div_req.go = 1'b0;
			end
		endcase
	end

	rsi_mul_serial u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	rsi_div_serial u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.rem_init (div_rem),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			period_q    <= PERIOD_RESET;
			p_q         <= PERIOD_BITS'(1);
			price_q     <= '0;
			restart_q   <= 1'b0;
			last_q      <= '0;
			avg_g_q     <= '0;
			avg_l_q     <= '0;
			seen_q      <= '0;
			gain_q      <= '0;
			loss_q      <= '0;
			side_q      <= 1'b0;
			sum_q       <= '0;
			num_q       <= '0;
			res_val_q   <= RSI_HALF;
			res_rdy_q   <= 1'b0;
			out_valid_q <= 1'b0;
			rsi_value_q <= RSI_HALF;
			ready_res_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						price_q   <= price[PRICE_BITS-1:0];
						restart_q <= restart;
						p_q       <= (period_q == '0) ? PERIOD_BITS'(1) : period_q;
						state_q   <= S_DIFF;
					end
				end
				S_DIFF: begin
					last_q <= price_q;
					side_q <= 1'b0;
					if (restart_q || seen_q == '0) begin
						avg_g_q   <= '0;
						avg_l_q   <= '0;
						seen_q    <= SEEN_BITS'(1);
						res_val_q <= RSI_HALF;
						res_rdy_q <= 1'b0;
						state_q   <= S_OUT;
					end else begin
						if (price_q > last_q) begin
							gain_q <= price_q - last_q;
							loss_q <= '0;
						end else begin
							gain_q <= '0;
							loss_q <= last_q - price_q;
						end
						state_q <= seed_mode ? S_SEED : S_SMUL;
					end
				end
				S_SEED: begin
					sum_q <= seed_sum;
					if (seed_end) begin
						state_q <= S_CDIV;
					end else begin
						if (side_q) begin
							avg_l_q <= seed_sum[AVG_BITS-1:0];
							state_q <= S_RSI;
						end else begin
							avg_g_q <= seed_sum[AVG_BITS-1:0];
							side_q  <= 1'b1;
						end
					end
				end
				S_CDIV: begin
					state_q <= S_DWAIT;
				end
				S_SMUL: begin
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (mul_done) begin
						num_q   <= NUM_BITS'(mul_prod) +
							NUM_BITS'({cur_chg, {AVG_FRAC{1'b0}}});
						state_q <= S_SDIV;
					end
				end
				S_SDIV: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						if (side_q) begin
							avg_l_q <= div_quo;
							state_q <= S_RSI;
						end else begin
							avg_g_q <= div_quo;
							side_q  <= 1'b1;
							state_q <= seed_mode ? S_SEED : S_SMUL;
						end
					end
				end
				S_RSI: begin
					seen_q <= seen_next;
					sum_q  <= {1'b0, avg_g_q} + {1'b0, avg_l_q};
					if (!ratio_ready) begin
						res_val_q <= RSI_HALF;
						res_rdy_q <= 1'b0;
						state_q   <= S_OUT;
					end else if (avg_l_q == '0) begin
						res_val_q <= RSI_FULL;
						res_rdy_q <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_RMUL;
					end
				end
				S_RMUL: begin
					state_q <= S_RMWAIT;
				end
				S_RMWAIT: begin
					if (mul_done) begin
						state_q <= S_RDIV;
					end
				end
				S_RDIV: begin
					state_q <= S_RDWAIT;
				end
				S_RDWAIT: begin
					if (div_done) begin
						res_val_q <= rounded[RSI_BITS:1];
						res_rdy_q <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						rsi_value_q <= res_val_q;
						ready_res_q <= res_rdy_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign rsi_value = rsi_value_q;
	assign ready_res = ready_res_q;

endmodule

// ===== bench/tb_streaming_rsi_indicator.sv =====
// Self-checking bench for streaming_rsi_indicator: a directed start, then random price series
// checked beat by beat against a Wilder RSI predictor held in a small scoreboard class.
// Depends on rsi_pkg and the streaming_rsi_indicator RTL.
module tb_streaming_rsi_indicator import rsi_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_WAIT  = 200;

	typedef struct packed {
		logic [RSI_BITS-1:0] rsi;
		logic                rdy;
	} rsi_beat_t;

	class rsi_scoreboard;
		logic [PERIOD_BITS-1:0] period = PERIOD_RESET;
		logic [PRICE_BITS-1:0]  last_tick;
		logic [AVG_BITS-1:0]    gain_avg;
		logic [AVG_BITS-1:0]    loss_avg;
		logic [SEEN_BITS-1:0]   prices_seen;
		rsi_beat_t              rsi_due[$];
		int                     errors;

		function new();
			last_tick   = '0;
			gain_avg    = '0;
			loss_avg    = '0;
			prices_seen = '0;
			errors      = 0;
		endfunction

		function int pending();
			return rsi_due.size();
		endfunction

		function void note_price(logic [31:0] px, logic rs);
			logic [63:0] p, gain, loss, wide, twice, g_sum, l_sum;
			rsi_beat_t   beat;
			p    = (period == 0) ? 64'd1 : 64'(period);
			gain = '0;
			loss = '0;
			beat = '{rsi: RSI_HALF, rdy: 1'b0};
			if (rs || prices_seen == 0) begin
				last_tick   = px[PRICE_BITS-1:0];
				gain_avg    = '0;
				loss_avg    = '0;
				prices_seen = SEEN_BITS'(1);
				rsi_due.insert(rsi_due.size(), beat);
				return;
			end
			if (px > last_tick)
				gain = 64'(px - last_tick);
			else
				loss = 64'(last_tick - px);
			last_tick = px;
			if (64'(prices_seen) <= p) begin
				g_sum = 64'(gain_avg) + gain;
				l_sum = 64'(loss_avg) + loss;
				if (64'(prices_seen) == p) begin
					// seed: plain mean of the summed changes
					g_sum = (g_sum << AVG_FRAC) / p;
					l_sum = (l_sum << AVG_FRAC) / p;
				end
				gain_avg = AVG_BITS'(g_sum);
				loss_avg = AVG_BITS'(l_sum);
			end else begin
				gain_avg = AVG_BITS'((64'(gain_avg) * (p - 1) + (gain << AVG_FRAC)) / p);
				loss_avg = AVG_BITS'((64'(loss_avg) * (p - 1) + (loss << AVG_FRAC)) / p);
			end
			if (prices_seen < SEEN_CAP)
				prices_seen = prices_seen + 1'b1;
			if (64'(prices_seen) > p) begin
				beat.rdy = 1'b1;
				if (loss_avg == 0) begin
					beat.rsi = RSI_FULL;
				end else begin
					wide     = 64'(gain_avg) + 64'(loss_avg);
					twice    = (64'(gain_avg) * (2 * 64'(RSI_FULL))) / wide;
					beat.rsi = RSI_BITS'((twice + 1) >> 1);
				end
			end
			rsi_due.insert(rsi_due.size(), beat);
		endfunction

		function void check_result(logic [RSI_BITS-1:0] rsi, logic rdy);
			rsi_beat_t want;
			if (rsi_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: rsi_value %0d ready_res %0b", rsi, rdy);
				return;
			end
			want = rsi_due.pop_front();
			if (want.rsi !== rsi || want.rdy !== rdy) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: rsi_value exp %0d got %0d, ready_res exp %0b got %0b",
						want.rsi, rsi, want.rdy, rdy);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [PERIOD_BITS-1:0] cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [31:0]            price;
	logic                   restart;
	logic                   out_valid;
	logic                   out_ready;
	logic [RSI_BITS-1:0]    rsi_value;
	logic                   ready_res;

	rsi_scoreboard sb = new();
	bit            idle_on = 1'b1;
	bit            hold_request = 1'b0;
	bit            hold_armed = 1'b0;
	logic [31:0]   walk_tick;
	int unsigned   quiet_cycles = 0;

	streaming_rsi_indicator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.price     (price),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rsi_value (rsi_value),
		.ready_res (ready_res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_price(input logic [31:0] px, input logic rs);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		price    <= px;
		restart  <= rs;
		do @(posedge clk); while (!in_ready);
		sb.note_price(px, rs);
	endtask

	task automatic program_period(input logic [PERIOD_BITS-1:0] val);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.period = val;
	endtask

	task automatic run_series(input logic [PERIOD_BITS-1:0] per, input int count,
			input bit restart_first, input int restart_pct);
		int   sel;
		logic rs;
		program_period(per);
		// long hold-off starts only once prices are flowing again
		if (hold_armed) begin
			hold_armed   = 1'b0;
			hold_request = 1'b1;
		end
		for (int i = 0; i < count; i++) begin
			rs = (i == 0 && restart_first) || ($urandom_range(0, 99) < restart_pct);
			sel = $urandom_range(0, 99);
			if (rs || sel >= 80 && sel < 90)
				walk_tick = $urandom;
			else if (sel < 60)
				walk_tick = walk_tick + $urandom_range(0, 2000) - 32'd1000;
			else if (sel < 80)
				walk_tick = walk_tick + $urandom_range(0, 1 << 20) - 32'd524288;
			send_price(walk_tick, rs);
		end
	endtask

	// result side: checks each beat, idles in bursts, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(rsi_value, ready_res);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		price     = '0;
		restart   = 1'b0;
		walk_tick = 32'h8000_0000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset period: falling series to ready (zero gain), then full-scale swings
		send_price(32'hFFFF_FFFF, 1'b0);
		for (int i = 1; i <= 14; i++)
			send_price(32'hFFFF_FFFF - i * i * 32'd12345, 1'b0);
		send_price(32'h0000_0000, 1'b0);
		send_price(32'hFFFF_FFFF, 1'b0);

		// period 0 runs as 1: flat, all gain, all loss
		program_period('0);
		send_price(32'h0000_0000, 1'b1);
		send_price(32'h0000_0000, 1'b0);
		send_price(32'hFFFF_FFFF, 1'b0);
		send_price(32'h0000_0000, 1'b0);

		// rising only: zero average loss
		program_period(PERIOD_BITS'(2));
		send_price(32'd10, 1'b1);
		send_price(32'd20, 1'b0);
		send_price(32'd30, 1'b0);

		// period drops below the change count while seeding
		run_series(PERIOD_BITS'(40), 10, 1'b1, 0);
		run_series(PERIOD_BITS'(5), 60, 1'b0, 0);
		// longest period, sample count saturates
		run_series(PERIOD_BITS'(255), 300, 1'b1, 0);
		hold_armed = 1'b1;
		run_series(PERIOD_BITS'(1), 80, 1'b1, 5);
		// period raised above the count mid-series
		run_series(PERIOD_BITS'(200), 30, 1'b0, 0);
		for (int k = 0; k < 8; k++) begin
			if (k == 7)
				idle_on = 1'b0;
			run_series(PERIOD_BITS'($urandom_range(2, 30)), 80, 1'b1, 3);
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
